### hw/rtl/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants for the pinned slot publication ring: the command
// and status codes, the request and result records, and the field widths.
// ----------------------------------------------------------------------------
package psr_pkg;

	// slot geometry; slot fields are three bits wide, so the ring stays small
	localparam int SLOT_COUNT = 4;
	localparam int SLOT_W     = 3;
	localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
	localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(SLOT_COUNT);

	// default reader pin counter width
	localparam int PIN_BITS_DEF = 8;

	// payload widths
	localparam int HANDLE_W = 32;
	localparam int GEN_W    = 64;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;

	// stream packing
	localparam int S_TDATA_W = 40;   // handle, slot index, zero fill
	localparam int M_TDATA_W = 104;  // slot, handle, generation, zero fill

	// operation codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUBLISH = 2'd0,
		CMD_ACQUIRE = 2'd1,
		CMD_RELEASE = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	// result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 3'd0,
		ST_BUSY      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_SATURATED = 3'd3,
		ST_IGNORED   = 3'd4
	} status_t;

	// one operation request
	typedef struct packed {
		cmd_t                command;
		logic [HANDLE_W-1:0] payload_handle;
		logic [SLOT_W-1:0]   slot_index;
	} req_t;

	// one operation result
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   out_slot;
		logic [HANDLE_W-1:0] out_handle;
		logic [GEN_W-1:0]    out_generation;
	} res_t;

endpackage

### hw/rtl/pinned_slot_publication_ring_top.sv
// ----------------------------------------------------------------------------
// pinned_slot_publication_ring_top
// Latest-value publication over a fixed set of buffer slots with reader pins.
// ----------------------------------------------------------------------------
// One operation (publish, acquire, release, clear) is taken per clock while
// the input stage is not stalled. An accepted request lands in an input
// register, is resolved against the slot state by the combinational decode,
// and its result is held in an output register, so a result is presented on
// m_tvalid after its request has passed the input and output registers. The
// slot state is decoded and updated in a single step; the input stage keeps
// accepting while a result waits for m_tready, and stalls only when both
// stages are full.
module pinned_slot_publication_ring_top #(
	parameter int PIN_BITS = psr_pkg::PIN_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [psr_pkg::S_TDATA_W-1:0] s_tdata,   // payload_handle, slot_index
	input  logic [psr_pkg::CMD_W-1:0]     s_tuser,   // command
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [psr_pkg::M_TDATA_W-1:0] m_tdata,   // out_slot, out_handle,
	                                                 // out_generation
	output logic [psr_pkg::STATUS_W-1:0]  m_tuser    // status
);
	import psr_pkg::*;

	logic valid_s1;
	req_t req_s1;
	logic advance;
	res_t res;
	res_t res_q;

	// stage flow
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.command        <= cmd_t'(s_tuser);
			req_s1.payload_handle <= s_tdata[HANDLE_W-1:0];
			req_s1.slot_index     <= s_tdata[HANDLE_W +: SLOT_W];
		end
	end

	psr_core #(
		.PIN_BITS (PIN_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.res    (res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	// pack result stream
	assign m_tuser = res_q.status;
	assign m_tdata = {{(M_TDATA_W - SLOT_W - HANDLE_W - GEN_W){1'b0}},
		res_q.out_generation, res_q.out_handle, res_q.out_slot};

endmodule

### hw/rtl/psr_gen.sv
// ----------------------------------------------------------------------------
// psr_gen
// Generation number source. Hands out the current number and moves on by one
// on each draw, wrapping past all ones to one so zero is never issued.
// ----------------------------------------------------------------------------
module psr_gen (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      draw,
	output logic [psr_pkg::GEN_W-1:0] gen
);
	import psr_pkg::*;

	logic [GEN_W-1:0] next_q;

	// counter, skips zero on wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= GEN_W'(1);
		end else if (draw) begin
			if (next_q == {GEN_W{1'b1}}) begin
				next_q <= GEN_W'(1);
			end else begin
				next_q <= next_q + GEN_W'(1);
			end
		end
	end

	assign gen = next_q;

endmodule

### hw/rtl/psr_core.sv
// ----------------------------------------------------------------------------
// psr_core
// Slot state and the combinational operation decode: pin counters, filled
// flags, current slot pointer, handle and generation stores. Computes the
// result of the staged request and commits the state update on step.
// ----------------------------------------------------------------------------
module psr_core #(
	parameter int PIN_BITS = psr_pkg::PIN_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  psr_pkg::req_t req,
	output psr_pkg::res_t res
);
	import psr_pkg::*;

	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

	// slot state
	logic [SLOT_W-1:0]   cur_q;
	logic [PIN_BITS-1:0] pin_q    [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] filled_q;
	logic [HANDLE_W-1:0] handle_q [SLOT_COUNT];
	logic [GEN_W-1:0]    gen_st_q [SLOT_COUNT];

	// next state and decode
	logic [SLOT_W-1:0]     cur_d;
	logic [PIN_BITS-1:0]   pin_d [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] filled_d;
	logic [SLOT_COUNT-1:0] free;
	logic [SLOT_BITS-1:0]  pick;
	logic [SLOT_BITS-1:0]  cur_idx;
	logic [SLOT_BITS-1:0]  rel_idx;
	logic                  wr_en;
	logic                  draw;
	logic [GEN_W-1:0]      gen;

	assign cur_idx = cur_q[SLOT_BITS-1:0];
	assign rel_idx = req.slot_index[SLOT_BITS-1:0];

	psr_gen u_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.draw   (step && draw),
		.gen    (gen)
	);

	// slots that publish may overwrite, lowest one wins
	always_comb begin
		pick = '0;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			free[s] = (cur_q != SLOT_W'(s)) && (pin_q[s] == '0);
		end
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (free[s]) begin
				pick = SLOT_BITS'(s);
			end
		end
	end

	// operation decode
	always_comb begin
		cur_d    = cur_q;
		pin_d    = pin_q;
		filled_d = filled_q;
		wr_en    = 1'b0;
		draw     = 1'b0;
		res      = '{status: ST_DONE, out_slot: NO_SLOT, out_handle: '0,
			out_generation: '0};
		case (req.command)
			CMD_PUBLISH: begin
				draw = 1'b1;
				if (|free) begin
					wr_en              = 1'b1;
					filled_d[pick]     = 1'b1;
					cur_d              = SLOT_W'(pick);
					res.out_slot       = SLOT_W'(pick);
					res.out_generation = gen;
				end else begin
					res.status = ST_BUSY;
				end
			end
			CMD_ACQUIRE: begin
				if (cur_q == NO_SLOT || !filled_q[cur_idx]) begin
					res.status = ST_EMPTY;
				end else if (pin_q[cur_idx] == PIN_MAX) begin
					res.status = ST_SATURATED;
				end else begin
					pin_d[cur_idx]     = pin_q[cur_idx] + PIN_BITS'(1);
					res.out_slot       = cur_q;
					res.out_handle     = handle_q[cur_idx];
					res.out_generation = gen_st_q[cur_idx];
				end
			end
			CMD_RELEASE: begin
				if (req.slot_index >= NO_SLOT || pin_q[rel_idx] == '0) begin
					res.status = ST_IGNORED;
				end else begin
					pin_d[rel_idx] = pin_q[rel_idx] - PIN_BITS'(1);
				end
			end
			CMD_CLEAR: begin
				cur_d = NO_SLOT;
				for (int s = 0; s < SLOT_COUNT; s++) begin
					if (pin_q[s] == '0) begin
						filled_d[s] = 1'b0;
					end
				end
			end
			default: begin
				res.status = ST_DONE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= NO_SLOT;
			filled_q <= '0;
			for (int s = 0; s < SLOT_COUNT; s++) begin
				pin_q[s] <= '0;
			end
		end else if (step) begin
			cur_q    <= cur_d;
			filled_q <= filled_d;
			pin_q    <= pin_d;
		end
	end

	// slot payload store, written on a successful publish
	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			handle_q[pick] <= req.payload_handle;
			gen_st_q[pick] <= gen;
		end
	end

	// current slot pointer holds a real slot or none
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= NO_SLOT)
		else $error("current slot out of range");

	// a current slot always has contents
	a_cur_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != NO_SLOT) |-> filled_q[cur_idx])
		else $error("current slot is not filled");

	// a successful publish makes its slot current
	a_pub_current: assert property (@(posedge clk) disable iff (!arst_n)
		(step && req.command == CMD_PUBLISH && res.status == ST_DONE)
		|=> (cur_q == $past(res.out_slot)))
		else $error("published slot did not become current");

	// a published generation is never zero
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(req.command == CMD_PUBLISH && res.status == ST_DONE)
		|-> (res.out_generation != '0))
		else $error("zero generation published");

endmodule
